// File: hdl/tel_pkg.sv
// shared constants for the terminal line editor: action codes, control bytes,
// command words and the item kinds passed between pipeline stages
// no dependencies
package tel_pkg;

    localparam int LINE_CAPACITY_DEF = 80;

    // action codes on the result channel
    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_ECHO      = 4'd1;
    localparam logic [3:0] ACT_LEFT      = 4'd2;
    localparam logic [3:0] ACT_RIGHT     = 4'd3;
    localparam logic [3:0] ACT_DELETE    = 4'd4;
    localparam logic [3:0] ACT_BACKSPACE = 4'd5;
    localparam logic [3:0] ACT_CLEAR     = 4'd6;
    localparam logic [3:0] ACT_QUIT      = 4'd7;
    localparam logic [3:0] ACT_PROMPT    = 4'd8;

    // control bytes
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;  // '['
    localparam logic [7:0] BYTE_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] BYTE_D     = 8'h44;  // 'D'
    localparam logic [7:0] BYTE_C     = 8'h43;  // 'C'
    localparam logic [7:0] BYTE_3     = 8'h33;  // '3'

    localparam int CLEAR_LEN = 5;
    localparam int QUIT_LEN  = 4;

    // what the second stage has to do with an item
    localparam logic [1:0] KIND_FIXED = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_BS    = 2'd2;
    localparam logic [1:0] KIND_ENTER = 2'd3;

    function automatic logic [7:0] clear_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h63;  // c
            3'd1:    c = 8'h6C;  // l
            3'd2:    c = 8'h65;  // e
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h72;  // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] quit_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h71;  // q
            3'd1:    c = 8'h75;  // u
            3'd2:    c = 8'h69;  // i
            3'd3:    c = 8'h74;  // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/tel_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module tel_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 80,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/terminal_escape_line_editor.sv
// terminal_escape_line_editor: console byte in, action code and echo byte out
// the result passes through the stage 1 register, then the output register
// throughput: one request per cycle while the output is not stalled; a backspace
//   reads a prefix-match entry from the line ram at accept time, used in stage 2
// reset: clears escape tracker, fill count and valid bits, sets the match flags;
//   the ram is not cleared, entries below the fill count are always written first
module terminal_escape_line_editor #(
    parameter int LINE_CAPACITY = tel_pkg::LINE_CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] action,
    output logic [7:0] echo_byte
);

    import tel_pkg::*;

    localparam int FILL_W = $clog2(LINE_CAPACITY);

    localparam logic [1:0] ESC_IDLE    = 2'd0;
    localparam logic [1:0] ESC_GOT     = 2'd1;
    localparam logic [1:0] ESC_BRACKET = 2'd2;
    localparam logic [1:0] ESC_THREE   = 2'd3;

    logic [1:0]        esc_reg, esc_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // stage 1: item accepted, ram read in flight
    logic              s1_valid_reg;
    logic [1:0]        s1_kind_reg, kind_next;
    logic [3:0]        s1_act_reg, act_next;
    logic [7:0]        s1_byte_reg;
    logic [FILL_W-1:0] s1_pos_reg;
    logic              s1_empty_reg;

    // prefix-match flags of the current line against "clear" and "quit"
    logic mc_reg, mc_next;
    logic mq_reg, mq_next;

    logic       out_valid_reg;
    logic [3:0] action_reg, action_next;
    logic [7:0] echo_reg;

    logic accept, advance;
    logic ram_wr_en, ram_rd_en;
    logic [1:0] ram_rd_data;
    logic store_c, store_q;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // escape tracking and fill bookkeeping
    always_comb
    begin
        logic normal;
        normal    = 1'b0;
        esc_next  = esc_reg;
        fill_next = fill_reg;
        kind_next = KIND_FIXED;
        act_next  = ACT_NONE;
        unique case (esc_reg)
            ESC_IDLE:
            begin
                if (rx_byte == BYTE_ESC)
                begin
                    esc_next = ESC_GOT;
                end
                else
                begin
                    normal = 1'b1;
                end
            end
            ESC_GOT:
            begin
                if (rx_byte == BYTE_LBRK)
                begin
                    esc_next = ESC_BRACKET;
                end
                else
                begin
                    esc_next = ESC_IDLE;
                    normal   = 1'b1;
                end
            end
            ESC_BRACKET:
            begin
                esc_next = ESC_IDLE;
                if (rx_byte == BYTE_D)
                begin
                    act_next = ACT_LEFT;
                end
                else if (rx_byte == BYTE_C)
                begin
                    act_next = ACT_RIGHT;
                end
                else if (rx_byte == BYTE_3)
                begin
                    esc_next = ESC_THREE;
                end
            end
            ESC_THREE:
            begin
                esc_next = ESC_IDLE;
                if (rx_byte == BYTE_TILDE)
                begin
                    act_next = ACT_DELETE;
                end
            end
            default:
            begin
                esc_next = ESC_IDLE;
            end
        endcase

        if (normal)
        begin
            if (rx_byte == BYTE_BS || rx_byte == BYTE_DEL)
            begin
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - 1'b1;
                    kind_next = KIND_BS;
                    act_next  = ACT_BACKSPACE;
                end
            end
            else if (rx_byte == BYTE_CR || rx_byte == BYTE_LF)
            begin
                fill_next = '0;
                kind_next = KIND_ENTER;
            end
            else
            begin
                act_next = ACT_ECHO;
                if (fill_reg < FILL_W'(LINE_CAPACITY - 1))
                begin
                    fill_next = fill_reg + 1'b1;
                    kind_next = KIND_STORE;
                end
            end
        end
    end

    // a backspace that leaves a non-empty line needs the flags of the new last entry
    assign ram_rd_en = accept && (kind_next == KIND_BS) && (fill_reg > FILL_W'(1));

    assign store_c = mc_reg && (s1_pos_reg < FILL_W'(CLEAR_LEN))
                     && (s1_byte_reg == clear_char(s1_pos_reg[2:0]));
    assign store_q = mq_reg && (s1_pos_reg < FILL_W'(QUIT_LEN))
                     && (s1_byte_reg == quit_char(s1_pos_reg[2:0]));

    assign ram_wr_en = advance && (s1_kind_reg == KIND_STORE);

    tel_ram #(
        .WIDTH (2),
        .DEPTH (LINE_CAPACITY)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_pos_reg),
        .wr_data ({store_c, store_q}),
        .rd_en   (ram_rd_en),
        .rd_addr (fill_reg - FILL_W'(2)),
        .rd_data (ram_rd_data)
    );

    // stage 2: resolve line commands and keep the match flags current
    always_comb
    begin
        mc_next     = mc_reg;
        mq_next     = mq_reg;
        action_next = s1_act_reg;
        unique case (s1_kind_reg)
            KIND_STORE:
            begin
                mc_next = store_c;
                mq_next = store_q;
            end
            KIND_BS:
            begin
                if (s1_empty_reg)
                begin
                    mc_next = 1'b1;
                    mq_next = 1'b1;
                end
                else
                begin
                    mc_next = ram_rd_data[1];
                    mq_next = ram_rd_data[0];
                end
            end
            KIND_ENTER:
            begin
                mc_next = 1'b1;
                mq_next = 1'b1;
                if (mc_reg && s1_pos_reg == FILL_W'(CLEAR_LEN))
                begin
                    action_next = ACT_CLEAR;
                end
                else if (mq_reg && s1_pos_reg == FILL_W'(QUIT_LEN))
                begin
                    action_next = ACT_QUIT;
                end
                else
                begin
                    action_next = ACT_PROMPT;
                end
            end
            default:
            begin
                mc_next = mc_reg;
                mq_next = mq_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= ESC_IDLE;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_kind_reg   <= KIND_FIXED;
            mc_reg        <= 1'b1;
            mq_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                esc_reg     <= esc_next;
                fill_reg    <= fill_next;
                s1_kind_reg <= kind_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mc_reg        <= mc_next;
                mq_reg        <= mq_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg   <= act_next;
            s1_byte_reg  <= rx_byte;
            s1_pos_reg   <= fill_reg;
            s1_empty_reg <= (fill_reg == FILL_W'(1));
        end
        if (advance)
        begin
            action_reg <= action_next;
            echo_reg   <= (action_next == ACT_ECHO) ? s1_byte_reg : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign echo_byte = echo_reg;

endmodule
